// ----- design/rc4_pkg.sv -----
`timescale 1ns / 1ps

package rc4_pkg;

    // table geometry
    localparam int unsigned TABLE_AW    = 8;
    localparam int unsigned TABLE_DEPTH = 256;

    // session key and the fixed tail of the eight-byte key
    localparam int unsigned SESSION_KEY_W = 40;
    localparam logic [7:0]  KEY_FIX5      = 8'he5;
    localparam logic [7:0]  KEY_FIX6      = 8'h38;
    localparam logic [7:0]  KEY_FIX7      = 8'hb0;

    // operation codes
    localparam logic OP_REKEY = 1'b0;
    localparam logic OP_CRYPT = 1'b1;

    typedef logic [7:0] byte_t;

    // one access request to the permutation memory, write side and read side
    typedef struct packed {
        logic                  we;
        logic [TABLE_AW-1:0]   waddr;
        byte_t                 wdata;
        logic                  re;
        logic [TABLE_AW-1:0]   raddr;
    } rc4_mem_req_t;

endpackage

// ----- design/rc4_keyed_stream_cipher.sv -----
`timescale 1ns / 1ps

// RC4 stream cipher engine around a single 256 x 8 permutation memory with one write
// and one registered read port. A crypt beat (op = 1) runs from acceptance to the
// output register through the read of S[i], the read of S[j], the first swap write
// together with the read of S[t], then the second swap write and the XOR, held while
// the output register is full. A rekey beat (op = 0) runs through the accepting
// cycle, the load of the identity, the priming of the first read, then per entry of
// the key schedule the read of S[j] and two swap writes, bound by the one memory
// port. No beat is accepted while the engine is busy; a finished result waits in the
// output register without holding up the next input beat. The session key must be
// written while the engine is idle and a crypt beat is only meaningful after a rekey.

module rc4_keyed_stream_cipher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rc4_pkg::SESSION_KEY_W-1:0]  cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [7:0]                         data_in,
    input  logic                               last_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         data_out,
    output logic                               last_out
);

    logic [rc4_pkg::SESSION_KEY_W-1:0] session_key_reg;
    rc4_pkg::rc4_mem_req_t             mem_req;
    rc4_pkg::byte_t                    mem_rdata;

    // session key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            session_key_reg <= cfg_wdata;
        end
    end

    // sequencer
    rc4_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .session_key (session_key_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .data_in     (data_in),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .last_out    (last_out),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    // permutation memory
    rc4_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

// ----- design/rc4_ram.sv -----
`timescale 1ns / 1ps

module rc4_ram
(
    input  logic                  clk,
    input  rc4_pkg::rc4_mem_req_t req,
    output rc4_pkg::byte_t        rdata
);

    rc4_pkg::byte_t mem [rc4_pkg::TABLE_DEPTH];
    rc4_pkg::byte_t rdata_reg;

    // one write port, one registered read port, write-first on a collision
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rdata_reg <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rc4_ctrl.sv -----
`timescale 1ns / 1ps

module rc4_ctrl
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [rc4_pkg::SESSION_KEY_W-1:0]      session_key,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  rc4_pkg::byte_t                         data_in,
    input  logic                                   last_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output rc4_pkg::byte_t                         data_out,
    output logic                                   last_out,
    output rc4_pkg::rc4_mem_req_t                  mem_req,
    input  rc4_pkg::byte_t                         mem_rdata
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_C_J    = 4'd1;
    localparam logic [3:0] ST_C_T    = 4'd2;
    localparam logic [3:0] ST_C_OUT  = 4'd3;
    localparam logic [3:0] ST_K_FILL = 4'd4;
    localparam logic [3:0] ST_K_RD   = 4'd5;
    localparam logic [3:0] ST_K_RJ   = 4'd6;
    localparam logic [3:0] ST_K_W1   = 4'd7;
    localparam logic [3:0] ST_K_W2   = 4'd8;

    localparam logic [rc4_pkg::TABLE_AW-1:0] LAST_ENTRY =
        rc4_pkg::TABLE_AW'(rc4_pkg::TABLE_DEPTH - 1);

    logic [3:0]                  state_reg, state_next;
    logic [rc4_pkg::TABLE_AW-1:0] i_reg, i_next;
    logic [rc4_pkg::TABLE_AW-1:0] j_reg, j_next;
    logic [rc4_pkg::TABLE_AW-1:0] n_reg, n_next;
    logic [rc4_pkg::TABLE_AW-1:0] t_reg, t_next;
    rc4_pkg::byte_t              si_reg, si_next;
    rc4_pkg::byte_t              din_reg, din_next;
    logic                        lin_reg, lin_next;
    logic                        out_valid_reg, out_valid_next;
    rc4_pkg::byte_t              data_out_reg, data_out_next;
    logic                        last_out_reg, last_out_next;

    logic [63:0]                 key_word;
    rc4_pkg::byte_t              key_byte;
    rc4_pkg::byte_t              ks_byte;
    logic                        accept;
    logic                        out_free;
    logic [rc4_pkg::TABLE_AW-1:0] j_sched;

    // eight-byte key, byte k in bits 8k+7 down to 8k
    assign key_word = {rc4_pkg::KEY_FIX7, rc4_pkg::KEY_FIX6, rc4_pkg::KEY_FIX5, session_key};
    assign key_byte = key_word[{n_reg[2:0], 3'b000} +: 8];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // entry j may have been the pending swap target of the t read
    assign ks_byte = (t_reg == j_reg) ? si_reg : mem_rdata;
    assign j_sched = j_reg + mem_rdata + key_byte;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        si_next        = si_reg;
        din_next       = din_reg;
        lin_next       = lin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        data_out_next  = data_out_reg;
        last_out_next  = last_out_reg;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == rc4_pkg::OP_CRYPT)
                    begin
                        i_next        = i_reg + 1'b1;
                        din_next      = data_in;
                        lin_next      = last_in;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = i_reg + 1'b1;
                        state_next    = ST_C_J;
                    end
                    else
                    begin
                        n_next     = '0;
                        j_next     = '0;
                        state_next = ST_K_FILL;
                    end
                end
            end
            ST_C_J:
            begin
                si_next       = mem_rdata;
                j_next        = j_reg + mem_rdata;
                mem_req.re    = 1'b1;
                mem_req.raddr = j_reg + mem_rdata;
                state_next    = ST_C_T;
            end
            ST_C_T:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = mem_rdata;
                mem_req.re    = 1'b1;
                mem_req.raddr = si_reg + mem_rdata;
                t_next        = si_reg + mem_rdata;
                state_next    = ST_C_OUT;
            end
            ST_C_OUT:
            begin
                if (out_free)
                begin
                    mem_req.we     = 1'b1;
                    mem_req.waddr  = j_reg;
                    mem_req.wdata  = si_reg;
                    out_valid_next = 1'b1;
                    data_out_next  = din_reg ^ ks_byte;
                    last_out_next  = lin_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_K_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = n_reg;
                n_next        = n_reg + 1'b1;
                if (n_reg == LAST_ENTRY)
                begin
                    state_next = ST_K_RD;
                end
            end
            ST_K_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = n_reg;
                state_next    = ST_K_RJ;
            end
            ST_K_RJ:
            begin
                si_next       = mem_rdata;
                j_next        = j_sched;
                mem_req.re    = 1'b1;
                mem_req.raddr = j_sched;
                state_next    = ST_K_W1;
            end
            ST_K_W1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = mem_rdata;
                state_next    = ST_K_W2;
            end
            ST_K_W2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = si_reg;
                if (n_reg == LAST_ENTRY)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    n_next        = n_reg + 1'b1;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = n_reg + 1'b1;
                    state_next    = ST_K_RJ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        si_reg       <= si_next;
        din_reg      <= din_next;
        lin_reg      <= lin_next;
        data_out_reg <= data_out_next;
        last_out_reg <= last_out_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign last_out  = last_out_reg;

endmodule

// ----- design/rc4_checker.sv -----
`timescale 1ns / 1ps

module rc4_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_out,
    input logic       last_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last_out))
        else $error("result beat changed while stalled");

    // one beat at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // crypt result delivery into an empty output register
    a_crypt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op && !out_valid
        |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 out_valid)
        else $error("crypt result not delivered after four cycles");

    // a fresh result means the engine has gone idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while engine busy");

endmodule

bind rc4_keyed_stream_cipher rc4_checker u_rc4_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .last_out  (last_out)
);
